/* rtl/core/bmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter package
// Shared constants, register codes and the types passed between the front
// part, the job queue and the back part of the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_WINDOW_DEF = 31;
   localparam int MAX_ROWS       = 4096;
   localparam int QUEUE_DEPTH    = 4;
   localparam int DIV_STEPS      = 26;

   localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd2;
   localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd3;
   localparam logic [2:0] REG_BORDER_VALUE  = 3'd4;

   localparam logic ACT_PIXEL = 1'b0;

   typedef struct packed {
      logic [10:0] width;
      logic [12:0] height;
      logic [3:0]  half_h;
      logic [3:0]  half_w;
      logic [7:0]  border;
      logic [12:0] border_col;
      logic [9:0]  area;
   } cfg_type;

   typedef struct packed {
      logic [11:0] row;
      logic [10:0] c_lo;
      logic [10:0] c_hi;
   } job_type;

   typedef struct packed {
      logic        en;
      logic [10:0] col;
      logic [12:0] data;
   } csum_wr_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_READ,
      F_SETTLE,
      F_DONE,
      F_WAIT
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SUM,
      B_SETTLE,
      B_DIV,
      B_PUT
   } back_state_type;

endpackage

/* rtl/core/bmf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter front part
// Accepts pixel items, keeps the line store, forms the vertical column sum
// and hands an emission job to the queue for each item that emits results.
// ----------------------------------------------------------------------------
module bmf_front import bmf_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        restart,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   output job_type     job,
   output logic        job_push,
   input  logic        job_ready,
   input  logic        queue_empty,
   input  logic        back_busy,
   output csum_wr_type csum_wr
);

   localparam int RING   = MAX_WINDOW - 1;
   localparam int SLOT_W = $clog2(RING);
   localparam int DEPTH  = RING * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);

   front_state_type    state_ff, state_in;
   logic [12:0]        row_ff, row_in;
   logic [10:0]        col_ff, col_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  rd_slot_ff, rd_slot_in;
   logic [7:0]         pix_ff, pix_in;
   logic [12:0]        acc_ff, acc_in;
   logic [4:0]         tap_ff, tap_in;
   logic signed [13:0] k_ff, k_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               rd_border_ff, rd_border_in;
   logic [7:0]         mem_q_ff;
   logic [7:0]         line_mem [DEPTH];

   logic [10:0]        c_eff;
   logic               in_img;
   logic               rowend;
   logic               emit;
   logic               rd_border;
   logic               mem_rd_en;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         add_val;
   logic [10:0]        c_lo;

   always_comb begin
      c_eff     = (col_ff >= cfg.width) ? cfg.width - 11'd1 : col_ff;
      in_img    = row_ff < cfg.height;
      rowend    = (12'(c_eff) + 12'd1) >= 12'(cfg.width);
      emit      = (row_ff >= 13'(cfg.half_h)) && (rowend || c_eff >= 11'(cfg.half_w));
      c_lo      = (c_eff >= 11'(cfg.half_w)) ? c_eff - 11'(cfg.half_w) : 11'd0;
      rd_border = (k_ff < 14'sd0) || (k_ff >= $signed({1'b0, cfg.height}));
      rd_addr   = ADDR_W'(rd_slot_ff * MAX_WIDTH) + ADDR_W'(c_eff);
      wr_addr   = ADDR_W'(slot_ff * MAX_WIDTH) + ADDR_W'(c_eff);
      add_val   = rd_border_ff ? cfg.border : mem_q_ff;
      job.row   = 12'(row_ff - 13'(cfg.half_h));
      job.c_lo  = c_lo;
      job.c_hi  = rowend ? c_eff : c_lo;
   end

   assign req_tready = (state_ff == F_IDLE);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      slot_in      = slot_ff;
      rd_slot_in   = rd_slot_ff;
      pix_in       = pix_ff;
      acc_in       = acc_ff;
      tap_in       = tap_ff;
      k_in         = k_ff;
      rd_pend_in   = 1'b0;
      rd_border_in = rd_border_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      job_push     = 1'b0;
      csum_wr      = '0;
      if (rd_pend_ff) begin
         acc_in = acc_ff + 13'(add_val);
      end
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               pix_in     = (in_img && req_tuser == ACT_PIXEL) ? req_tdata : cfg.border;
               acc_in     = 13'(pix_in);
               tap_in     = 5'd1;
               k_in       = $signed({1'b0, row_ff}) - 14'sd1;
               rd_slot_in = (slot_ff == '0) ? SLOT_W'(RING - 1) : slot_ff - 1'b1;
               state_in   = (cfg.half_h == 4'd0) ? F_DONE : F_READ;
            end
         end
         F_READ: begin
            rd_pend_in   = 1'b1;
            rd_border_in = rd_border;
            mem_rd_en    = !rd_border;
            tap_in       = tap_ff + 5'd1;
            k_in         = k_ff - 14'sd1;
            rd_slot_in   = (rd_slot_ff == '0) ? SLOT_W'(RING - 1) : rd_slot_ff - 1'b1;
            if (tap_ff == {cfg.half_h, 1'b0}) begin
               state_in = F_SETTLE;
            end
         end
         F_SETTLE: begin
            state_in = F_DONE;
         end
         F_DONE: begin
            if (!emit || job_ready) begin
               mem_wr_en = in_img;
               csum_wr   = '{en: 1'b1, col: c_eff, data: acc_ff};
               job_push  = emit;
               if (rowend) begin
                  col_in = 11'd0;
                  if ((14'(row_ff) + 14'd1) >= (14'(cfg.height) + 14'(cfg.half_h))) begin
                     row_in  = 13'd0;
                     slot_in = '0;
                  end else begin
                     row_in  = row_ff + 13'd1;
                     slot_in = (slot_ff == SLOT_W'(RING - 1)) ? '0 : slot_ff + 1'b1;
                  end
                  state_in = F_WAIT;
               end else begin
                  col_in   = c_eff + 11'd1;
                  state_in = F_IDLE;
               end
            end
         end
         F_WAIT: begin
            if (queue_empty && !back_busy) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
      if (restart) begin
         row_in  = 13'd0;
         col_in  = 11'd0;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         row_ff     <= 13'd0;
         col_ff     <= 11'd0;
         slot_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         slot_ff    <= slot_in;
         rd_pend_ff <= rd_pend_in;
      end
      rd_slot_ff   <= rd_slot_in;
      pix_ff       <= pix_in;
      acc_ff       <= acc_in;
      tap_ff       <= tap_in;
      k_ff         <= k_in;
      rd_border_ff <= rd_border_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         line_mem[wr_addr] <= pix_ff;
      end
      if (mem_rd_en) begin
         mem_q_ff <= line_mem[rd_addr];
      end
   end

endmodule

/* rtl/core/bmf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter job queue
// A short first-in first-out queue of emission jobs between the front and
// the back part.
// ----------------------------------------------------------------------------
module bmf_queue import bmf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output job_type pop_data,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      empty      = !pop_valid;
      pop_data   = slot_ff[rd_ptr_ff];
      do_push    = push && push_ready;
      do_pop     = pop && pop_valid;
      wr_ptr_in  = do_push ? PTR_W'((CNT_W + 1)'(wr_ptr_ff) + 1'b1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? PTR_W'((CNT_W + 1)'(rd_ptr_ff) + 1'b1) : rd_ptr_ff;
      count_in   = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/bmf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter back part
// Holds the column sums, runs each job over its result columns, adds the
// horizontal window, divides by the window area and presents the item.
// ----------------------------------------------------------------------------
module bmf_back import bmf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  csum_wr_type csum_wr,
   input  logic        job_valid,
   input  job_type     job_in,
   output logic        job_pop,
   output logic        busy,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int IDX_W = $clog2(MAX_WIDTH);

   back_state_type     state_ff, state_in;
   job_type            job_ff, job_in_r;
   logic [10:0]        c_ff, c_in;
   logic [4:0]         n_ff, n_in;
   logic signed [12:0] x_ff, x_in;
   logic [17:0]        acc_ff, acc_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               rd_border_ff, rd_border_in;
   logic [12:0]        q_ff;
   logic [9:0]         rem_ff, rem_in;
   logic [25:0]        quo_ff, quo_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic               out_valid_ff, out_valid_in;
   logic [15:0]        mean_ff, mean_in;
   logic [11:0]        orow_ff, orow_in;
   logic [9:0]         ocol_ff, ocol_in;
   logic               olast_ff, olast_in;
   logic [12:0]        csum_mem [MAX_WIDTH];

   logic               rd_border;
   logic               rd_en;
   logic [10:0]        t_trial;
   logic               load_out;

   always_comb begin
      rd_border = (x_ff < 13'sd0) || (x_ff >= $signed({2'b00, cfg.width}));
      t_trial   = {rem_ff, quo_ff[25]};
      busy      = state_ff != B_IDLE;
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {2'b00, ocol_ff, orow_ff, mean_ff};
      rsp_tlast  = olast_ff;
   end

   always_comb begin
      state_in     = state_ff;
      job_in_r     = job_ff;
      c_in         = c_ff;
      n_in         = n_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      rd_pend_in   = 1'b0;
      rd_border_in = rd_border_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      mean_in      = mean_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      olast_in     = olast_ff;
      rd_en        = 1'b0;
      job_pop      = 1'b0;
      load_out     = 1'b0;
      if (rd_pend_ff) begin
         acc_in = acc_ff + (rd_border_ff ? 18'(cfg.border_col) : 18'(q_ff));
      end
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in_r = job_in;
               c_in     = job_in.c_lo;
               n_in     = 5'd0;
               x_in     = $signed({2'b00, job_in.c_lo}) - $signed({9'd0, cfg.half_w});
               acc_in   = 18'd0;
               state_in = B_SUM;
            end
         end
         B_SUM: begin
            rd_pend_in   = 1'b1;
            rd_border_in = rd_border;
            rd_en        = !rd_border;
            n_in         = n_ff + 5'd1;
            x_in         = x_ff + 13'sd1;
            if (n_ff == {cfg.half_w, 1'b0}) begin
               state_in = B_SETTLE;
            end
         end
         B_SETTLE: begin
            quo_in   = {acc_in, 8'd0};
            rem_in   = 10'd0;
            dcnt_in  = 5'd0;
            state_in = B_DIV;
         end
         B_DIV: begin
            if (t_trial >= {1'b0, cfg.area}) begin
               rem_in = 10'(t_trial - {1'b0, cfg.area});
               quo_in = {quo_ff[24:0], 1'b1};
            end else begin
               rem_in = t_trial[9:0];
               quo_in = {quo_ff[24:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = B_PUT;
            end
         end
         B_PUT: begin
            if (!out_valid_ff || rsp_tready) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               mean_in      = quo_ff[15:0];
               orow_in      = job_ff.row;
               ocol_in      = c_ff[9:0];
               olast_in     = c_ff == job_ff.c_hi;
               if (c_ff == job_ff.c_hi) begin
                  state_in = B_IDLE;
               end else begin
                  c_in     = c_ff + 11'd1;
                  n_in     = 5'd0;
                  x_in     = $signed({2'b00, c_ff + 11'd1}) - $signed({9'd0, cfg.half_w});
                  acc_in   = 18'd0;
                  state_in = B_SUM;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff       <= job_in_r;
      c_ff         <= c_in;
      n_ff         <= n_in;
      x_ff         <= x_in;
      acc_ff       <= acc_in;
      rd_border_ff <= rd_border_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dcnt_ff      <= dcnt_in;
      if (load_out) begin
         mean_ff  <= mean_in;
         orow_ff  <= orow_in;
         ocol_ff  <= ocol_in;
         olast_ff <= olast_in;
      end
   end

   always_ff @(posedge clock) begin
      if (csum_wr.en) begin
         csum_mem[IDX_W'(csum_wr.col)] <= csum_wr.data;
      end
      if (rd_en) begin
         q_ff <= csum_mem[IDX_W'(x_ff[11:0])];
      end
   end

endmodule

/* rtl/core/box_mean_filter_const_border.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter with constant border
// Top level: register port, front part, job queue and back part.
// ----------------------------------------------------------------------------
// Each pixel item passes through the front part with one line store read per
// window row above it (none when hv is zero), plus a wait at each row end
// until the back part has drained that row. Each result in the back part takes
// one column sum read per window column, then a 26 step restoring divider by
// the window area. A four entry job queue lets the front part run ahead of the
// back part. Flush items, one per raster position, drain the last hv rows after
// the frame.
module box_mean_filter_const_border import bmf_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // pixel[7:0]
   input  logic        req_tuser,    // action[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // mean_q8[15:0], out_row[27:16], out_col[37:28]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int MAXW_CAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
   localparam int WIN_CAP  = (((MAX_WINDOW - 1) | 1) > 31) ? 31 : ((MAX_WINDOW - 1) | 1);

   logic [10:0] img_w_ff, img_w_in;
   logic [12:0] img_h_ff, img_h_in;
   logic [4:0]  win_h_ff, win_h_in;
   logic [4:0]  win_w_ff, win_w_in;
   logic [7:0]  border_ff, border_in;
   logic        restart;
   logic        wr_en;
   logic [2:0]  reg_idx;
   logic [4:0]  eff_h;
   logic [4:0]  eff_w;
   cfg_type     cfg;

   job_type     front_job;
   logic        job_push;
   logic        job_ready;
   logic        queue_empty;
   logic        back_busy;
   csum_wr_type csum_wr;
   logic        job_pop;
   logic        job_valid;
   job_type     back_job;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      img_w_in  = img_w_ff;
      img_h_in  = img_h_ff;
      win_h_in  = win_h_ff;
      win_w_in  = win_w_ff;
      border_in = border_ff;
      restart   = 1'b0;
      if (wr_en) begin
         unique case (reg_idx)
            REG_IMAGE_WIDTH: begin
               img_w_in = csr_pwdata[10:0];
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               img_h_in = csr_pwdata[12:0];
               restart  = 1'b1;
            end
            REG_WINDOW_HEIGHT: begin
               win_h_in = csr_pwdata[4:0];
               restart  = 1'b1;
            end
            REG_WINDOW_WIDTH: begin
               win_w_in = csr_pwdata[4:0];
               restart  = 1'b1;
            end
            REG_BORDER_VALUE: begin
               border_in = csr_pwdata[7:0];
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_IMAGE_WIDTH:   csr_prdata = 32'(img_w_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = 32'(img_h_ff);
         REG_WINDOW_HEIGHT: csr_prdata = 32'(win_h_ff);
         REG_WINDOW_WIDTH:  csr_prdata = 32'(win_w_ff);
         REG_BORDER_VALUE:  csr_prdata = 32'(border_ff);
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= 11'd640;
         img_h_ff  <= 13'd480;
         win_h_ff  <= 5'd19;
         win_w_ff  <= 5'd19;
         border_ff <= 8'd120;
      end else begin
         img_w_ff  <= img_w_in;
         img_h_ff  <= img_h_in;
         win_h_ff  <= win_h_in;
         win_w_ff  <= win_w_in;
         border_ff <= border_in;
      end
   end

   always_comb begin
      eff_h = ((win_h_ff | 5'd1) > 5'(WIN_CAP)) ? 5'(WIN_CAP) : (win_h_ff | 5'd1);
      eff_w = ((win_w_ff | 5'd1) > 5'(WIN_CAP)) ? 5'(WIN_CAP) : (win_w_ff | 5'd1);
      if (img_w_ff == 11'd0) begin
         cfg.width = 11'd1;
      end else if (img_w_ff > 11'(MAXW_CAP)) begin
         cfg.width = 11'(MAXW_CAP);
      end else begin
         cfg.width = img_w_ff;
      end
      if (img_h_ff == 13'd0) begin
         cfg.height = 13'd1;
      end else if (img_h_ff > 13'(MAX_ROWS)) begin
         cfg.height = 13'(MAX_ROWS);
      end else begin
         cfg.height = img_h_ff;
      end
      cfg.half_h     = eff_h[4:1];
      cfg.half_w     = eff_w[4:1];
      cfg.border     = border_ff;
      cfg.border_col = 13'(eff_h * border_ff);
      cfg.area       = 10'(eff_h * eff_w);
   end

   bmf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .restart     (restart),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .job         (front_job),
      .job_push    (job_push),
      .job_ready   (job_ready),
      .queue_empty (queue_empty),
      .back_busy   (back_busy),
      .csum_wr     (csum_wr)
   );

   bmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (front_job),
      .push_ready (job_ready),
      .pop        (job_pop),
      .pop_valid  (job_valid),
      .pop_data   (back_job),
      .empty      (queue_empty)
   );

   bmf_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .csum_wr    (csum_wr),
      .job_valid  (job_valid),
      .job_in     (back_job),
      .job_pop    (job_pop),
      .busy       (back_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/core/bmf_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter port checker
// Watches the top level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module bmf_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [4:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // The output register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item shown right after reset");

   // A stalled result item keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   // The front part works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while the previous one is in work");

   // A mean never exceeds full scale and the pad bits stay clear.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] <= 16'hFF00) && (rsp_tdata[39:38] == 2'b00))
      else $error("result item out of range");

endmodule

bind box_mean_filter_const_border bmf_chk u_chk (.*);
